[rtl/ibmw_pkg.sv]
// Shared types, field widths and codes for the inode block map walker.
package ibmw_pkg;

  localparam int STORE_BLOCKS_DEF   = 1024;
  localparam int PTRS_PER_BLOCK_DEF = 32;
  localparam int DIRECT_COUNT_DEF   = 5;

  localparam int ACTION_W = 2;
  localparam int BLOCK_W  = 10;
  localparam int WORD_W   = 5;
  localparam int VALUE_W  = 32;
  localparam int LBLOCK_W = 16;
  localparam int STATUS_W = 2;

  localparam logic [ACTION_W-1:0] ACT_STORE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SLOT  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_XLATE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_RANGE  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BADPTR = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIVM,
    S_DIVR,
    S_FETCH,
    S_LOAD
  } state_t;

endpackage

[rtl/ibmw_ram.sv]
// Generic single-port RAM with registered read.
module ibmw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/ibmw_divp.sv]
// Divide-by-pointer-count step: reciprocal multiply, then remainder with correction.
module ibmw_divp #(
  parameter int PTRS_PER_BLOCK = ibmw_pkg::PTRS_PER_BLOCK_DEF
) (
  input  logic                              clk,
  input  logic [ibmw_pkg::LBLOCK_W-1:0]     x,
  output logic [ibmw_pkg::LBLOCK_W-1:0]     q,
  output logic [$clog2(PTRS_PER_BLOCK)-1:0] r
);
  import ibmw_pkg::*;

  localparam int IDX_W  = $clog2(PTRS_PER_BLOCK);
  localparam int SHIFT  = LBLOCK_W + IDX_W;
  localparam int MUL_W  = LBLOCK_W + 2;
  localparam int PROD_W = LBLOCK_W + MUL_W;
  localparam longint unsigned MUL =
    ((longint'(1) << SHIFT) + longint'(PTRS_PER_BLOCK) - 1) / longint'(PTRS_PER_BLOCK);

  logic [PROD_W-1:0]   prod;
  logic [LBLOCK_W-1:0] xr;
  logic [LBLOCK_W-1:0] q_raw;
  logic [31:0]         rem;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(x) * PROD_W'(MUL_W'(MUL));
    xr   <= x;
  end

  always_comb begin
    q_raw = LBLOCK_W'(prod >> SHIFT);
    rem   = 32'(xr) - 32'(q_raw) * 32'(PTRS_PER_BLOCK);
    if (rem >= 32'(PTRS_PER_BLOCK)) begin
      q = q_raw + LBLOCK_W'(1);
      r = IDX_W'(rem - 32'(PTRS_PER_BLOCK));
    end else begin
      q = q_raw;
      r = IDX_W'(rem);
    end
  end

endmodule

[rtl/ibmw_agen.sv]
// Store address unit: bounds check of block pointer and word, flat word address.
module ibmw_agen #(
  parameter int STORE_BLOCKS   = ibmw_pkg::STORE_BLOCKS_DEF,
  parameter int PTRS_PER_BLOCK = ibmw_pkg::PTRS_PER_BLOCK_DEF,
  parameter int WI_W           = ibmw_pkg::WORD_W
) (
  input  logic [ibmw_pkg::VALUE_W-1:0]                    ptr,
  input  logic [WI_W-1:0]                                 word,
  output logic                                            ok,
  output logic [$clog2(STORE_BLOCKS*PTRS_PER_BLOCK)-1:0]  addr
);
  import ibmw_pkg::*;

  localparam int BLK_W  = $clog2(STORE_BLOCKS);
  localparam int ADDR_W = $clog2(STORE_BLOCKS * PTRS_PER_BLOCK);

  always_comb begin
    ok   = (ptr < VALUE_W'(STORE_BLOCKS)) && (32'(word) < 32'(PTRS_PER_BLOCK));
    addr = ADDR_W'(ADDR_W'(ptr[BLK_W-1:0]) * ADDR_W'(PTRS_PER_BLOCK)) + ADDR_W'(word);
  end

endmodule

[rtl/inode_block_map_walker.sv]
// Inode block map walker: logical to physical block translation through a pointer map.
//
// An item is taken when start is high and busy is low; its result shows on
// physical_block and status for one cycle with done high, and the receiver
// must take it then. Busy is already low in that cycle. Writes, unused actions,
// direct blocks and out-of-range blocks finish in the decode state. Indirect
// blocks chase pointers through the single store port (an address state and a
// registered read per level); double and triple indirect blocks first pass
// through the shared divide-by-pointer-count step, one pass for double and
// two for triple indirect. A bad pointer ends the walk at the level that
// finds it. No clearing pass: store words must be written before use.
module inode_block_map_walker #(
  parameter int STORE_BLOCKS   = ibmw_pkg::STORE_BLOCKS_DEF,
  parameter int PTRS_PER_BLOCK = ibmw_pkg::PTRS_PER_BLOCK_DEF,
  parameter int DIRECT_COUNT   = ibmw_pkg::DIRECT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ibmw_pkg::ACTION_W-1:0] action,
  input  logic [ibmw_pkg::BLOCK_W-1:0]  block_index,
  input  logic [ibmw_pkg::WORD_W-1:0]   word_index,
  input  logic [ibmw_pkg::VALUE_W-1:0]  word_value,
  input  logic [ibmw_pkg::LBLOCK_W-1:0] logical_block,
  output logic                          done,
  output logic [ibmw_pkg::VALUE_W-1:0]  physical_block,
  output logic [ibmw_pkg::STATUS_W-1:0] status
);
  import ibmw_pkg::*;

  localparam int SLOTS  = DIRECT_COUNT + 3;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int IDX_W  = $clog2(PTRS_PER_BLOCK);
  localparam int WI_W   = (IDX_W > WORD_W) ? IDX_W : WORD_W;
  localparam int DEPTH  = STORE_BLOCKS * PTRS_PER_BLOCK;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam longint unsigned P_L   = longint'(PTRS_PER_BLOCK);
  localparam longint unsigned T_SGL = longint'(DIRECT_COUNT);
  localparam longint unsigned T_DBL = T_SGL + P_L;
  localparam longint unsigned T_TPL = T_DBL + P_L * P_L;
  localparam longint unsigned T_END = T_TPL + P_L * P_L * P_L;

  state_t state, state_next;

  logic [ACTION_W-1:0] act;
  logic [BLOCK_W-1:0]  blk;
  logic [WORD_W-1:0]   wrd;
  logic [VALUE_W-1:0]  val;
  logic [LBLOCK_W-1:0] lb;

  logic [VALUE_W-1:0]  slots [SLOTS];

  logic [VALUE_W-1:0]  ptr, ptr_next;
  logic [IDX_W-1:0]    idx [3];
  logic [IDX_W-1:0]    idx_next [3];
  logic [1:0]          step, step_next;
  logic [1:0]          levels, levels_next;
  logic                second, second_next;
  logic [LBLOCK_W-1:0] dividend, dividend_next;

  logic                done_next;
  logic [VALUE_W-1:0]  phys_next;
  logic [STATUS_W-1:0] stat_next;

  logic                slot_we;

  logic [VALUE_W-1:0]  ag_ptr;
  logic [WI_W-1:0]     ag_word;
  logic                ag_ok;
  logic [ADDR_W-1:0]   ag_addr;
  logic                ram_we;
  logic [VALUE_W-1:0]  ram_rdata;

  logic [LBLOCK_W-1:0] div_q;
  logic [IDX_W-1:0]    div_r;

  logic [63:0]         lb_wide;

  assign busy    = (state != S_IDLE);
  assign lb_wide = 64'(lb);

  ibmw_agen #(
    .STORE_BLOCKS  (STORE_BLOCKS),
    .PTRS_PER_BLOCK(PTRS_PER_BLOCK),
    .WI_W          (WI_W)
  ) u_agen (
    .ptr (ag_ptr),
    .word(ag_word),
    .ok  (ag_ok),
    .addr(ag_addr)
  );

  ibmw_divp #(
    .PTRS_PER_BLOCK(PTRS_PER_BLOCK)
  ) u_divp (
    .clk(clk),
    .x  (dividend),
    .q  (div_q),
    .r  (div_r)
  );

  ibmw_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ag_addr),
    .wdata(val),
    .rdata(ram_rdata)
  );

  always_comb begin
    if (state == S_DECODE) begin
      ag_ptr  = VALUE_W'(blk);
      ag_word = WI_W'(wrd);
    end else begin
      ag_ptr  = ptr;
      ag_word = WI_W'(idx[step]);
    end
  end

  assign ram_we = (state == S_DECODE) && (act == ACT_STORE) && ag_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slots[i] <= '0;
      end
    end else begin
      state <= state_next;
      done  <= done_next;
      if (slot_we) begin
        slots[blk[SLOT_W-1:0]] <= val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      act <= action;
      blk <= block_index;
      wrd <= word_index;
      val <= word_value;
      lb  <= logical_block;
    end
    ptr            <= ptr_next;
    idx            <= idx_next;
    step           <= step_next;
    levels         <= levels_next;
    second         <= second_next;
    dividend       <= dividend_next;
    physical_block <= phys_next;
    status         <= stat_next;
  end

  always_comb begin
    state_next    = state;
    ptr_next      = ptr;
    idx_next      = idx;
    step_next     = step;
    levels_next   = levels;
    second_next   = second;
    dividend_next = dividend;
    done_next     = 1'b0;
    phys_next     = physical_block;
    stat_next     = status;
    slot_we       = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        phys_next   = '0;
        stat_next   = STAT_OK;
        step_next   = 2'd0;
        second_next = 1'b0;
        case (act)
          ACT_SLOT: begin
            slot_we    = (32'(blk) < 32'(SLOTS));
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
          ACT_XLATE: begin
            if (lb_wide < T_SGL) begin
              phys_next  = slots[lb[SLOT_W-1:0]];
              done_next  = 1'b1;
              state_next = S_IDLE;
            end else if (lb_wide < T_DBL) begin
              ptr_next    = slots[DIRECT_COUNT];
              idx_next[0] = IDX_W'(lb - LBLOCK_W'(T_SGL));
              levels_next = 2'd1;
              state_next  = S_FETCH;
            end else if (lb_wide < T_TPL) begin
              ptr_next      = slots[DIRECT_COUNT + 1];
              dividend_next = lb - LBLOCK_W'(T_DBL);
              levels_next   = 2'd2;
              state_next    = S_DIVM;
            end else if (lb_wide < T_END) begin
              ptr_next      = slots[DIRECT_COUNT + 2];
              dividend_next = lb - LBLOCK_W'(T_TPL);
              levels_next   = 2'd3;
              state_next    = S_DIVM;
            end else begin
              stat_next  = STAT_RANGE;
              done_next  = 1'b1;
              state_next = S_IDLE;
            end
          end
          default: begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end

      S_DIVM: begin
        state_next = S_DIVR;
      end

      S_DIVR: begin
        if (levels == 2'd3 && !second) begin
          idx_next[2]   = div_r;
          dividend_next = div_q;
          second_next   = 1'b1;
          state_next    = S_DIVM;
        end else begin
          idx_next[0] = IDX_W'(div_q);
          idx_next[1] = div_r;
          state_next  = S_FETCH;
        end
      end

      S_FETCH: begin
        if (!ag_ok) begin
          phys_next  = '0;
          stat_next  = STAT_BADPTR;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_LOAD;
        end
      end

      S_LOAD: begin
        if (step == levels - 2'd1) begin
          phys_next  = ram_rdata;
          stat_next  = STAT_OK;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          ptr_next   = ram_rdata;
          step_next  = step + 2'd1;
          state_next = S_FETCH;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[sim/tb.sv]
// Testbench for the inode block map walker: directed and random map walks checked by a predictor.
module tb;
  import ibmw_pkg::*;

  localparam int NBLK        = STORE_BLOCKS_DEF;
  localparam int NPTR        = PTRS_PER_BLOCK_DEF;
  localparam int NDIRECT     = DIRECT_COUNT_DEF;
  localparam int NSLOT       = NDIRECT + 3;
  localparam int NWORDS      = NBLK * NPTR;
  localparam int SINGLE_BASE = NDIRECT;
  localparam int DOUBLE_BASE = SINGLE_BASE + NPTR;
  localparam int TRIPLE_BASE = DOUBLE_BASE + NPTR * NPTR;
  localparam int MAP_END     = TRIPLE_BASE + NPTR * NPTR * NPTR;
  localparam int NUM_ITEMS   = 1650;
  localparam int WATCHDOG    = 2000;
  localparam int GEN         = 0;
  localparam int CHK         = 1;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BLOCK_W-1:0]  block_index;
    logic [WORD_W-1:0]   word_index;
    logic [VALUE_W-1:0]  word_value;
    logic [LBLOCK_W-1:0] logical_block;
  } map_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  physical_block;
    logic [STATUS_W-1:0] status;
  } map_result_t;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                start         = 1'b0;
  logic [ACTION_W-1:0] action        = '0;
  logic [BLOCK_W-1:0]  block_index   = '0;
  logic [WORD_W-1:0]   word_index    = '0;
  logic [VALUE_W-1:0]  word_value    = '0;
  logic [LBLOCK_W-1:0] logical_block = '0;
  logic                busy;
  logic                done;
  logic [VALUE_W-1:0]  physical_block;
  logic [STATUS_W-1:0] status;

  // index 0: generator view of the map, index 1: predictor view
  bit [VALUE_W-1:0] slot_ptr      [2][NSLOT];
  bit [VALUE_W-1:0] map_store     [2][NWORDS];
  bit               store_written [2][NWORDS];

  map_item_t   walk_requests[$];
  map_result_t expected_blocks[$];
  map_item_t   drive_item;
  map_result_t want;
  int          queued_count   = 0;
  int          total_items    = 0;
  int          accepted_count = 0;
  int          errors         = 0;
  int          idle_cycles    = 0;
  int          burst_left     = 1;
  int          gap_left       = 0;
  int          unused_miss;
  bit          unused_last;

  inode_block_map_walker u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .block_index   (block_index),
    .word_index    (word_index),
    .word_value    (word_value),
    .logical_block (logical_block),
    .done          (done),
    .physical_block(physical_block),
    .status        (status)
  );

  always #10 clk = ~clk;

  // Applies one item to a view of the map; reports the first never-written word the walk reads.
  function automatic map_result_t map_lookup(input int side, input map_item_t it,
                                             output int miss_word, output bit miss_last);
    map_result_t        res;
    int                 lb;
    int                 levels;
    int                 addr;
    int                 idx [3];
    logic [VALUE_W-1:0] ptr;
    bit                 walking;
    res = '0;
    miss_word = -1;
    miss_last = 1'b0;
    levels = 0;
    ptr = '0;
    idx = '{0, 0, 0};
    case (it.action)
      ACT_STORE: begin
        if (int'(it.block_index) < NBLK && int'(it.word_index) < NPTR) begin
          addr = int'(it.block_index) * NPTR + int'(it.word_index);
          map_store[side][addr] = it.word_value;
          store_written[side][addr] = 1'b1;
        end
      end
      ACT_SLOT: begin
        if (int'(it.block_index) < NSLOT) slot_ptr[side][it.block_index] = it.word_value;
      end
      ACT_XLATE: begin
        lb = int'(it.logical_block);
        if (lb < SINGLE_BASE) begin
          res.physical_block = slot_ptr[side][lb];
        end else if (lb < DOUBLE_BASE) begin
          levels = 1;
          ptr = slot_ptr[side][NDIRECT];
          idx[0] = lb - SINGLE_BASE;
        end else if (lb < TRIPLE_BASE) begin
          levels = 2;
          ptr = slot_ptr[side][NDIRECT + 1];
          lb = lb - DOUBLE_BASE;
          idx[0] = lb / NPTR;
          idx[1] = lb % NPTR;
        end else if (lb < MAP_END) begin
          levels = 3;
          ptr = slot_ptr[side][NDIRECT + 2];
          lb = lb - TRIPLE_BASE;
          idx[0] = lb / (NPTR * NPTR);
          idx[1] = (lb / NPTR) % NPTR;
          idx[2] = lb % NPTR;
        end else begin
          res.status = STAT_RANGE;
        end
        walking = levels > 0;
        for (int k = 0; k < levels; k++) begin
          if (walking) begin
            if (ptr >= NBLK) begin
              res.status = STAT_BADPTR;
              walking = 1'b0;
            end else begin
              addr = int'(ptr) * NPTR + idx[k];
              if (!store_written[side][addr] && miss_word < 0) begin
                miss_word = addr;
                miss_last = (k == levels - 1);
              end
              ptr = map_store[side][addr];
            end
          end
        end
        if (walking) res.physical_block = ptr;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic map_item_t random_item(input logic [ACTION_W-1:0] act);
    map_item_t it;
    it.action        = act;
    it.block_index   = BLOCK_W'($urandom);
    it.word_index    = WORD_W'($urandom);
    it.word_value    = $urandom;
    it.logical_block = LBLOCK_W'($urandom);
    return it;
  endfunction

  // Mostly a few shared blocks so chains get reused; some pointers land outside the store.
  function automatic logic [VALUE_W-1:0] pick_pointer();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return VALUE_W'($urandom_range(0, 15));
    if (r < 88) return VALUE_W'($urandom_range(0, NBLK - 1));
    if (r < 94) return VALUE_W'(NBLK);
    return $urandom | VALUE_W'(NBLK);
  endfunction

  task automatic queue_item(input map_item_t it);
    map_result_t res;
    int          miss;
    bit          last;
    res = map_lookup(GEN, it, miss, last);
    walk_requests.push_back(it);
    if (!(it.action == ACT_UNUSED || (it.action == ACT_SLOT && int'(it.block_index) >= NSLOT)))
      queued_count++;
  endtask

  task automatic queue_slot(input int slot, input logic [VALUE_W-1:0] value);
    map_item_t it;
    it = random_item(ACT_SLOT);
    it.block_index = BLOCK_W'(slot);
    it.word_value = value;
    queue_item(it);
  endtask

  task automatic queue_store(input int addr, input logic [VALUE_W-1:0] value);
    map_item_t it;
    it = random_item(ACT_STORE);
    it.block_index = BLOCK_W'(addr / NPTR);
    it.word_index = WORD_W'(addr % NPTR);
    it.word_value = value;
    queue_item(it);
  endtask

  // Writes every pointer word the walk would read before it is written, then the translate.
  task automatic queue_walk(input int lb);
    map_item_t   it;
    map_result_t res;
    int          miss;
    bit          last;
    it = random_item(ACT_XLATE);
    it.logical_block = LBLOCK_W'(lb);
    for (int tries = 0; tries < 4; tries++) begin
      res = map_lookup(GEN, it, miss, last);
      if (miss >= 0) queue_store(miss, last ? $urandom : pick_pointer());
    end
    queue_item(it);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_blocks.push_back(map_lookup(CHK, drive_item, unused_miss, unused_last));
        accepted_count++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
        end
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (walk_requests.size() > 0) begin
          drive_item = walk_requests.pop_front();
          action <= drive_item.action;
          block_index <= drive_item.block_index;
          word_index <= drive_item.word_index;
          word_value <= drive_item.word_value;
          logical_block <= drive_item.logical_block;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: result with none expected: expected nothing actual %h/%0d",
                 $time, physical_block, status);
        errors++;
      end else begin
        want = expected_blocks.pop_front();
        if (physical_block !== want.physical_block) begin
          $display("%0t: physical_block expected %h actual %h",
                   $time, want.physical_block, physical_block);
          errors++;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    map_item_t it;
    int        r;
    int        slot;
    int        lb;
    queue_walk(0);
    queue_slot(0, 32'hFFFF_FFFF);
    queue_slot(NDIRECT - 1, 32'h0000_0001);
    queue_walk(0);
    queue_walk(NDIRECT - 1);
    queue_slot(NSLOT, $urandom);
    queue_slot(1023, $urandom);
    it = random_item(ACT_UNUSED);
    it.block_index = '1;
    it.word_index = '1;
    it.word_value = '1;
    it.logical_block = '1;
    queue_item(it);
    queue_slot(NDIRECT, NBLK - 1);
    queue_store(NWORDS - 1, 32'hFFFF_FFFF);
    queue_walk(DOUBLE_BASE - 1);
    queue_slot(NDIRECT + 1, NBLK);
    queue_walk(DOUBLE_BASE);
    queue_slot(NDIRECT + 2, 0);
    queue_store(0, 32'hFFFF_FFFF);
    queue_walk(TRIPLE_BASE);
    queue_walk(MAP_END);
    queue_walk(65535);
    queue_slot(NDIRECT + 1, 1);
    queue_walk(TRIPLE_BASE - 1);
    queue_walk(MAP_END - 1);
    queue_walk(SINGLE_BASE);

    while (queued_count < NUM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        r = $urandom_range(0, 99);
        if (r < 10) lb = $urandom_range(0, NDIRECT - 1);
        else if (r < 28) lb = $urandom_range(SINGLE_BASE, DOUBLE_BASE - 1);
        else if (r < 53) lb = $urandom_range(DOUBLE_BASE, TRIPLE_BASE - 1);
        else if (r < 85) lb = $urandom_range(TRIPLE_BASE, MAP_END - 1);
        else if (r < 93) lb = $urandom_range(MAP_END, 65535);
        else lb = $urandom_range(0, 65535);
        queue_walk(lb);
      end else if (r < 77) begin
        slot = ($urandom_range(0, 9) == 0) ? $urandom_range(NSLOT, 1023)
                                           : $urandom_range(0, NSLOT - 1);
        queue_slot(slot, (slot >= NDIRECT) ? pick_pointer() : $urandom);
      end else if (r < 95) begin
        queue_store($urandom_range(0, NWORDS - 1),
                    ($urandom_range(0, 1) == 0) ? pick_pointer() : $urandom);
      end else begin
        queue_item(random_item(ACT_UNUSED));
      end
    end
    total_items = walk_requests.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (accepted_count < total_items) @(posedge clk);
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
rtl/ibmw_pkg.sv
rtl/ibmw_ram.sv
rtl/ibmw_divp.sv
rtl/ibmw_agen.sv
rtl/inode_block_map_walker.sv
sim/tb.sv
